// ===== src/bbq_pkg.sv =====
// shared types and constants for the bounded bag core
// no dependencies; imported by every module of the block but bbq_ram

package bbq_pkg;

    localparam int VAL_W        = 32;
    localparam int KIND_W       = 2;
    localparam int CNT_W        = 5;
    localparam int DEF_CAPACITY = 16;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 8;

    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(16);

    typedef logic [KIND_W-1:0] req_kind_t;

    localparam req_kind_t REQ_INSERT = 2'd0;
    localparam req_kind_t REQ_REMOVE = 2'd1;
    localparam req_kind_t REQ_QUERY  = 2'd2;

    typedef struct packed {
        logic load_req;
        logic run;
        logic shift_wr;
        logic found;
        logic pop;
        logic load_out;
    } bbq_cmd_t;

    typedef struct packed {
        req_kind_t kind;
        req_kind_t in_kind;
        logic      empty;
        logic      hit;
        logic      cmp_valid;
        logic      rd_done;
        logic      out_free;
    } bbq_sts_t;

endpackage

// ===== src/bbq_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module bbq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/bbq_datapath.sv =====
// datapath of the bounded bag: entry ram, count, limit, scan pointers, result register
// depends on bbq_pkg and bbq_ram; driven by bbq_ctrl through bbq_cmd_t

module bbq_datapath
    import bbq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  bbq_cmd_t               cmd,
    output bbq_sts_t               sts,
    input  logic [KIND_W-1:0]      in_kind,
    input  logic [VAL_W-1:0]       in_value,
    input  logic                   cfg_wr_en,
    input  logic [CNT_W-1:0]       cfg_wr_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_ok,
    output logic [CNT_W-1:0]       m_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    req_kind_t        kind_reg;
    logic [VAL_W-1:0] value_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] limit_reg;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] cmp_idx_reg;
    logic             cmp_valid_reg;
    logic             ok_reg, ok_next;
    logic             m_valid_reg;
    logic             m_ok_reg;
    logic [CNT_W-1:0] m_count_reg;

    logic             ins_ok;
    logic             ins_do;
    logic             rd_issue;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [VAL_W-1:0] ram_wdata;
    logic [VAL_W-1:0] ram_rdata;

    assign ins_ok   = (count_reg < limit_reg) && (32'(count_reg) < CAPACITY);
    assign ins_do   = cmd.load_req && (in_kind == REQ_INSERT) && ins_ok;
    assign rd_issue = cmd.run && (rd_idx_reg < count_reg);

    assign ram_we    = ins_do || (cmd.shift_wr && cmp_valid_reg);
    assign ram_waddr = cmd.load_req ? AW'(count_reg) : AW'(cmp_idx_reg - CNT_W'(1));
    assign ram_wdata = cmd.load_req ? in_value : ram_rdata;

    bbq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (AW'(rd_idx_reg)),
        .rdata (ram_rdata)
    );

    always_comb begin
        count_next = count_reg;
        if (ins_do) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.pop) begin
            count_next = count_reg - CNT_W'(1);
        end

        ok_next = ok_reg;
        if (cmd.load_req) begin
            ok_next = ins_do;
        end else if (cmd.found || cmd.pop) begin
            ok_next = 1'b1;
        end

        rd_idx_next = rd_idx_reg;
        if (cmd.load_req) begin
            rd_idx_next = '0;
        end else if (rd_issue) begin
            rd_idx_next = rd_idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            limit_reg     <= LIMIT_RESET;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_valid_reg <= rd_issue;
            ok_reg        <= ok_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            kind_reg  <= in_kind;
            value_reg <= in_value;
        end
        if (rd_issue) begin
            cmp_idx_reg <= rd_idx_reg;
        end
        if (cmd.load_out) begin
            m_ok_reg    <= ok_reg;
            m_count_reg <= count_reg;
        end
    end

    always_comb begin
        sts.kind      = kind_reg;
        sts.in_kind   = in_kind;
        sts.empty     = (count_reg == '0);
        sts.hit       = cmp_valid_reg && (ram_rdata == value_reg);
        sts.cmp_valid = cmp_valid_reg;
        sts.rd_done   = (rd_idx_reg == count_reg);
        sts.out_free  = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_ok    = m_ok_reg;
    assign m_count = m_count_reg;

`ifndef ASSERT_OFF
    a_grow_below_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg > $past(count_reg)) |-> ($past(count_reg) < $past(limit_reg)))
        else $error("count grew at or above the limit");

    a_shift_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.shift_wr && cmp_valid_reg) |-> ((cmp_idx_reg != '0) && (cmp_idx_reg < count_reg)))
        else $error("shift write outside held entries");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            ((count_reg == $past(count_reg) + CNT_W'(1)) ||
             (count_reg == $past(count_reg) - CNT_W'(1))))
        else $error("count moved by more than one");
`endif

endmodule

// ===== src/bbq_ctrl.sv =====
// controller state machine of the bounded bag: sequences insert, scan and shift-down
// depends on bbq_pkg; commands bbq_datapath through bbq_cmd_t, reads bbq_sts_t

module bbq_ctrl
    import bbq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  bbq_sts_t sts,
    output bbq_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_SHIFT = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    if ((sts.in_kind == REQ_REMOVE || sts.in_kind == REQ_QUERY) && !sts.empty) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                cmd.run = 1'b1;
                if (sts.hit) begin
                    if (sts.kind == REQ_QUERY) begin
                        cmd.found  = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SHIFT;
                    end
                end else if (!sts.cmp_valid && sts.rd_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT: begin
                cmd.run      = 1'b1;
                cmd.shift_wr = 1'b1;
                if (!sts.cmp_valid) begin
                    cmd.pop    = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    a_shift_only_remove: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT) |-> (sts.kind == REQ_REMOVE))
        else $error("shift-down entered for a request other than remove");
`endif

endmodule

// ===== src/bounded_bag_insert_remove_query_core.sv =====
// Bounded bag of signed 32-bit values kept in insertion order.
// Input channel (s_): one request item per handshake; s_tuser carries the
// request kind (insert, remove first match, query), s_tdata the value.
// Result channel (m_): one item per request with the ok flag and the count
// of held entries after the request.
// cfg_wr_en / cfg_wr_data set the entry limit (saturates to CAPACITY).
// Sequencing: insert, unknown kind, or remove/query on an empty bag go
// from acceptance straight to the done state and the output register.
// Remove and query scan the entry RAM one entry per cycle (one read port,
// registered read) and a remove then shifts later entries down one per
// cycle. One request is in work at a time.
// The result sits in an output register, so the next request is accepted
// while a finished result waits; a stalled m_tready only holds the block
// once a second result is ready.
// Reset empties the bag and sets the limit to 16; the entry RAM is not
// cleared, no wait after reset.
// depends on bbq_pkg, bbq_ctrl, bbq_datapath, bbq_ram

module bounded_bag_insert_remove_query_core
    import bbq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] value
    input  logic [KIND_W-1:0]      s_tuser,   // [1:0] req_type
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] ok, [5:1] count_after, [7:6] zero
    input  logic                   cfg_wr_en,
    input  logic [CNT_W-1:0]       cfg_wr_data
);

    bbq_cmd_t         cmd;
    bbq_sts_t         sts;
    logic             m_ok;
    logic [CNT_W-1:0] m_count;

    bbq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bbq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .in_kind     (s_tuser),
        .in_value    (s_tdata[VAL_W-1:0]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_ok        (m_ok),
        .m_count     (m_count)
    );

    assign m_tdata = {(OUT_TDATA_W - CNT_W - 1)'(0), m_count, m_ok};

endmodule

// ===== bench/bounded_bag_insert_remove_query_core_test.sv =====
// testbench for bounded_bag_insert_remove_query_core: insert, remove and query items
// are checked against an in-bench bag predictor, with limit writes and random stalls
// depends on bbq_pkg and the core rtl

module bounded_bag_insert_remove_query_core_test;
    import bbq_pkg::*;

    localparam req_kind_t REQ_UNUSED = 2'd3;
    localparam int        HOLD_LONG  = 400;
    localparam int        STALL_LIMIT = 3000;
    localparam int        DRAIN_WAIT = DEF_CAPACITY + 8;

    typedef struct packed {
        logic             ok;
        logic [CNT_W-1:0] count;
    } bag_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [KIND_W-1:0]      s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]       cfg_wr_data = '0;

    // predictor state
    logic [VAL_W-1:0] bag_vals [DEF_CAPACITY];
    logic [CNT_W-1:0] bag_count = '0;
    logic [CNT_W-1:0] bag_limit = LIMIT_RESET;
    bag_result_t      pending_results [$];

    bit          idling = 1'b0;
    int          hold_requests = 0;
    int          holds_served = 0;
    int          hold_left = 0;
    int          stall_left = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    bag_result_t want;

    bounded_bag_insert_remove_query_core #(
        .CAPACITY(DEF_CAPACITY)
    ) u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic bag_result_t bag_apply(req_kind_t kind, logic [VAL_W-1:0] v);
        int          lim;
        int          n;
        int          pos;
        bag_result_t r;
        lim = (bag_limit > DEF_CAPACITY) ? DEF_CAPACITY : bag_limit;
        n = bag_count;
        pos = n;
        for (int i = n - 1; i >= 0; i--) begin
            if (bag_vals[i] == v) pos = i;
        end
        r.ok = 1'b0;
        case (kind)
            REQ_INSERT: begin
                if (n < lim) begin
                    bag_vals[n] = v;
                    n++;
                    r.ok = 1'b1;
                end
            end
            REQ_REMOVE: begin
                if (pos < n) begin
                    for (int j = pos; j < n - 1; j++) bag_vals[j] = bag_vals[j + 1];
                    n--;
                    r.ok = 1'b1;
                end
            end
            REQ_QUERY: r.ok = (pos < n);
            default: ;
        endcase
        bag_count = CNT_W'(n);
        r.count = bag_count;
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = (bag_count > 0) ? bag_vals[$urandom_range(0, bag_count - 1)] : $urandom;
            1: v = $urandom_range(0, 7);
            2: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = 32'hffff_ffff;
                    default: v = '0;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_item(req_kind_t kind, logic [VAL_W-1:0] v);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(bag_apply(kind, v));
        if (idling && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    task automatic set_limit(logic [CNT_W-1:0] lim);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lim;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        bag_limit = lim;
    endtask

    task automatic test_directed();
        send_item(REQ_QUERY, 32'd5);
        send_item(REQ_REMOVE, 32'd5);
        send_item(REQ_INSERT, 32'h8000_0000);
        send_item(REQ_INSERT, 32'h7fff_ffff);
        send_item(REQ_INSERT, 32'h0000_0000);
        send_item(REQ_INSERT, 32'hffff_ffff);
        send_item(REQ_INSERT, 32'h0000_0000);
        send_item(REQ_QUERY, 32'h0000_0000);
        send_item(REQ_QUERY, 32'h7fff_ffff);
        send_item(REQ_QUERY, 32'h0000_0001);
        // first of two equal entries goes, the later one stays
        send_item(REQ_REMOVE, 32'h0000_0000);
        send_item(REQ_QUERY, 32'h0000_0000);
        send_item(REQ_REMOVE, 32'h8000_0000);
        send_item(REQ_REMOVE, 32'hffff_ffff);
        send_item(REQ_UNUSED, 32'h7fff_ffff);
        send_item(REQ_REMOVE, 32'd12345);
    endtask

    task automatic test_limit_edges();
        set_limit(5'd0);
        send_item(REQ_INSERT, 32'd9);
        // limit below the held count
        set_limit(5'd1);
        send_item(REQ_INSERT, 32'd9);
        send_item(REQ_QUERY, 32'h7fff_ffff);
        send_item(REQ_REMOVE, 32'h7fff_ffff);
        send_item(REQ_REMOVE, 32'h0000_0000);
        send_item(REQ_INSERT, 32'd3);
        send_item(REQ_INSERT, 32'd4);
    endtask

    task automatic test_random_mix(int n, int insert_pct);
        req_kind_t kind;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < insert_pct) begin
                kind = REQ_INSERT;
            end else begin
                case ($urandom_range(0, 9))
                    0: kind = REQ_UNUSED;
                    1, 2, 3, 4: kind = REQ_REMOVE;
                    default: kind = REQ_QUERY;
                endcase
            end
            send_item(kind, pick_value());
        end
    endtask

    task automatic test_backpressure();
        idling = 1'b0;
        hold_requests++;
        test_random_mix(40, 50);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_limit_edges();

        set_limit(5'd31);
        idling = 1'b1;
        test_random_mix(120, 70);
        set_limit(5'd3);
        test_random_mix(100, 30);
        set_limit(5'd16);
        idling = 1'b0;
        test_random_mix(100, 55);
        set_limit(CNT_W'($urandom_range(2, 15)));
        idling = 1'b1;
        test_random_mix(120, 50);
        set_limit(5'd1);
        test_random_mix(60, 50);
        set_limit(5'd16);
        test_random_mix(100, 60);

        test_backpressure();

        // steady tail, no idling on either side
        idling = 1'b0;
        test_random_mix(100, 50);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // result checker and receiver stalls
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result item: ok %0b count %0d", m_tdata[0], m_tdata[5:1]);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.ok || m_tdata[5:1] !== want.count) begin
                    if (mismatches < 10)
                        $display("mismatch: expected ok %0b count %0d, got ok %0b count %0d",
                                 want.ok, want.count, m_tdata[0], m_tdata[5:1]);
                    mismatches++;
                end
            end
        end
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left = HOLD_LONG;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idling && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 12);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
